>>> src/utf16_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
// Holds the encoder result struct, the byte constants and the register map.
// No dependencies.
package utf16_pkg;

	// Configuration port geometry.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic [0:0] REG_STOP_AT_ZERO = 1'b0;

	// Code unit classification.
	localparam logic [15:0] SURR_MASK = 16'hFC00;
	localparam logic [15:0] HIGH_SURR = 16'hD800;
	localparam logic [15:0] LOW_SURR  = 16'hDC00;
	localparam logic [20:0] SUPP_BASE = 21'h10000;

	// UTF-8 lead and continuation marks.
	localparam logic [7:0] CONT_MARK  = 8'h80;
	localparam logic [7:0] LEAD2_MARK = 8'hC0;
	localparam logic [7:0] LEAD3_MARK = 8'hE0;
	localparam logic [7:0] LEAD4_MARK = 8'hF0;
	localparam logic [7:0] SUBST_BYTE = 8'h3F;

	// Everything one code unit produces, plus the next hold state.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [3:0]      subst;
		logic [2:0]      count;
		logic            held_valid;
		logic [9:0]      held_bits;
	} enc_res_t;

endpackage

>>> src/utf16_enc.sv
// Combinational encoder: one UTF-16 code unit plus the surrogate hold state
// gives up to four UTF-8 bytes and the next hold state.
// Depends on utf16_pkg.
module utf16_enc (
	input  logic              [15:0] code_unit,
	input  logic                     end_of_text,
	input  logic                     stop_at_zero,
	input  logic                     held_valid,
	input  logic              [9:0]  held_bits,
	output utf16_pkg::enc_res_t      res
);
	import utf16_pkg::*;

	logic            is_high;
	logic            is_low;
	logic            is_stop;
	logic [20:0]     cp;
	logic [2:0][7:0] cur_bytes;
	logic [2:0]      cur_subst;
	logic [1:0]      cur_count;

	assign is_high = (code_unit & SURR_MASK) == HIGH_SURR;
	assign is_low  = (code_unit & SURR_MASK) == LOW_SURR;
	assign is_stop = stop_at_zero && (code_unit == 16'h0000);
	assign cp      = {1'b0, held_bits, code_unit[9:0]} + SUPP_BASE;

	// Bytes caused by the current unit alone, ignoring any held surrogate.
	always_comb begin
		cur_bytes = '0;
		cur_subst = '0;
		cur_count = 2'd0;
		if (is_stop) begin
			cur_count = 2'd0;
		end else if (is_high) begin
			if (end_of_text) begin
				cur_bytes[0] = SUBST_BYTE;
				cur_subst[0] = 1'b1;
				cur_count    = 2'd1;
			end
		end else if (is_low) begin
			cur_bytes[0] = SUBST_BYTE;
			cur_subst[0] = 1'b1;
			cur_count    = 2'd1;
		end else if (code_unit < 16'h0080) begin
			cur_bytes[0] = {1'b0, code_unit[6:0]};
			cur_count    = 2'd1;
		end else if (code_unit < 16'h0800) begin
			cur_bytes[0] = LEAD2_MARK | {3'b000, code_unit[10:6]};
			cur_bytes[1] = CONT_MARK | {2'b00, code_unit[5:0]};
			cur_count    = 2'd2;
		end else begin
			cur_bytes[0] = LEAD3_MARK | {4'h0, code_unit[15:12]};
			cur_bytes[1] = CONT_MARK | {2'b00, code_unit[11:6]};
			cur_bytes[2] = CONT_MARK | {2'b00, code_unit[5:0]};
			cur_count    = 2'd3;
		end
	end

	// Merge with the held surrogate: a pair, a leading '?', or nothing extra.
	always_comb begin
		res = '0;
		if (held_valid && is_low) begin
			res.bytes[0] = LEAD4_MARK | {5'b00000, cp[20:18]};
			res.bytes[1] = CONT_MARK | {2'b00, cp[17:12]};
			res.bytes[2] = CONT_MARK | {2'b00, cp[11:6]};
			res.bytes[3] = CONT_MARK | {2'b00, cp[5:0]};
			res.count    = 3'd4;
		end else if (held_valid) begin
			res.bytes = {cur_bytes, SUBST_BYTE};
			res.subst = {cur_subst, 1'b1};
			res.count = {1'b0, cur_count} + 3'd1;
		end else begin
			res.bytes = {8'h00, cur_bytes};
			res.subst = {1'b0, cur_subst};
			res.count = {1'b0, cur_count};
		end

		// A high surrogate is held unless the text ends here.
		if (!is_stop && is_high && !end_of_text && !(held_valid && is_low)) begin
			res.held_valid = 1'b1;
			res.held_bits  = code_unit[9:0];
		end else begin
			res.held_valid = 1'b0;
			res.held_bits  = held_bits;
		end
	end

endmodule

>>> src/utf16_to_utf8_transcoder.sv
// UTF-16 to UTF-8 transcoder top level: input register, encoder, byte buffer
// and the APB-style configuration register.
// Depends on utf16_pkg and utf16_enc.
//
// Usage: each input transaction carries one UTF-16 code unit and an
// end_of_text flag. Each output transaction carries one UTF-8 byte; the last
// byte a code unit causes has last_in_run set, and a '?' that replaces a bad
// surrogate has substituted set. A held high surrogate or a terminating zero
// may cause no output at all.
// The first byte of a code unit passes through the input register and then the
// byte buffer. The byte buffer sends one byte per cycle while the receiver does
// not stall, and a code unit causes up to four bytes; single-byte text flows at
// one code unit per cycle while the receiver does not stall.
// A new code unit is taken while the buffer still sends earlier bytes.
// When the receiver stalls, the current byte holds still, and once the input
// register is full in_stall is raised back to the sender.
// Reset clears stop_at_zero, the surrogate hold and all valid flags.
// Register 0 (byte address 0): stop_at_zero in bit 0.
module utf16_to_utf8_transcoder (
	input  logic                           clk,
	input  logic                           arst_n,
	// Input channel.
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [15:0]                    code_unit,
	input  logic                           end_of_text,
	// Output channel.
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     out_byte,
	output logic                           last_in_run,
	output logic                           substituted,
	// Configuration port.
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [utf16_pkg::ADDR_W-1:0]   paddr,
	input  logic [utf16_pkg::DATA_W-1:0]   pwdata,
	output logic [utf16_pkg::DATA_W-1:0]   prdata,
	output logic                           pready
);
	import utf16_pkg::*;

	logic            stop_at_zero_q;
	logic            held_valid_q;
	logic [9:0]      held_bits_q;

	logic            valid_s1;
	logic [15:0]     unit_s1;
	logic            eot_s1;

	logic            valid_s2;
	logic [3:0][7:0] bytes_s2;
	logic [3:0]      subst_s2;
	logic [2:0]      count_s2;
	logic [1:0]      idx_s2;

	enc_res_t        enc;
	logic            in_fire;
	logic            out_fire;
	logic            out_last;
	logic            s2_free;
	logic            advance;
	logic            reg_sel;

	// Configuration register access.
	assign pready  = 1'b1;
	assign reg_sel = paddr[ADDR_W-1:2] == REG_STOP_AT_ZERO;
	assign prdata  = reg_sel ? {{(DATA_W-1){1'b0}}, stop_at_zero_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_at_zero_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			stop_at_zero_q <= pwdata[0];
		end
	end

	// Handshake control.
	assign out_last = ({1'b0, idx_s2} + 3'd1) == count_s2;
	assign out_fire = valid_s2 && !out_stall;
	assign s2_free  = !valid_s2 || (out_fire && out_last);
	assign advance  = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign in_fire  = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			unit_s1 <= code_unit;
			eot_s1  <= end_of_text;
		end
	end

	utf16_enc u_enc (
		.code_unit    (unit_s1),
		.end_of_text  (eot_s1),
		.stop_at_zero (stop_at_zero_q),
		.held_valid   (held_valid_q),
		.held_bits    (held_bits_q),
		.res          (enc)
	);

	// Surrogate hold, updated as each code unit leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_bits_q  <= '0;
		end else if (advance) begin
			held_valid_q <= enc.held_valid;
			held_bits_q  <= enc.held_bits;
		end
	end

	// Byte buffer: loads a code unit's bytes and sends them one per cycle while out_stall is low.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_s2   <= '0;
		end else if (advance) begin
			valid_s2 <= enc.count != 3'd0;
			idx_s2   <= '0;
		end else if (out_fire) begin
			if (out_last) begin
				valid_s2 <= 1'b0;
			end else begin
				idx_s2 <= idx_s2 + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			bytes_s2 <= enc.bytes;
			subst_s2 <= enc.subst;
			count_s2 <= enc.count;
		end
	end

	assign out_valid   = valid_s2;
	assign out_byte    = bytes_s2[idx_s2];
	assign substituted = subst_s2[idx_s2];
	assign last_in_run = out_last;

endmodule
